// ===== rtl/core/mns_pkg.sv =====
// Shared types, constants and the pitch frequency table of the note sequencer.
`timescale 1ns / 1ps

package mns_pkg;

    localparam int DEFAULT_SONG_DEPTH    = 1024;
    localparam int DEFAULT_CHANNELS      = 4;
    localparam int DEFAULT_PITCH_ENTRIES = 256;

    localparam int ADDR_W      = 10;
    localparam int PITCH_W     = 8;
    localparam int DELAY_W     = 8;
    localparam int ENTRY_W     = PITCH_W + DELAY_W;
    localparam int FREQ_W      = 30;
    localparam int CHANNEL_W   = 2;
    localparam int ACTION_W    = 2;
    localparam int SOUND_W     = 2;
    localparam int PAN_W       = 8;
    localparam int COUNT_W     = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int ROM_DEPTH   = 256;

    localparam int NUM_START_REGS = 4;
    localparam int DRUM_CHANNEL   = 3;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_STOP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TONE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_DRUM = 2'd3;

    localparam logic [SOUND_W-1:0] SND_BASS  = 2'd0;
    localparam logic [SOUND_W-1:0] SND_SNARE = 2'd1;
    localparam logic [SOUND_W-1:0] SND_HIHAT = 2'd2;

    localparam logic [PAN_W-1:0] PAN_BASS  = 8'd128;
    localparam logic [PAN_W-1:0] PAN_SNARE = 8'd160;
    localparam logic [PAN_W-1:0] PAN_HIHAT = 8'd96;

    localparam logic [PITCH_W-1:0] NOTE_BASS  = 8'd1;
    localparam logic [PITCH_W-1:0] NOTE_SNARE = 8'd2;

    localparam longint unsigned DEC_ONE  = 64'd10000000000000000;
    localparam longint unsigned BASE_HZ  = 64'd350;
    localparam int              OCTAVE   = 12;
    localparam int              MAX_OCT  = 21;

    localparam longint unsigned SEMITONE_RATIO [OCTAVE] = '{
        64'd10000000000000000, 64'd10594630943592953, 64'd11224620483093730,
        64'd11892071150027211, 64'd12599210498948732, 64'd13348398541700344,
        64'd14142135623730950, 64'd14983070768766815, 64'd15874010519681994,
        64'd16817928305074290, 64'd17817974362806786, 64'd18877486253633869
    };

    typedef logic [FREQ_W-1:0] freq_t;
    typedef freq_t freq_rom_t [ROM_DEPTH];

    typedef struct packed {
        logic mem_write;
        logic rd_cur;
        logic rd_next;
        logic latch_entry;
        logic commit_due;
        logic commit_skip;
    } mns_cmd_t;

    typedef struct packed {
        logic due;
        logic slot_free;
    } mns_status_t;

    function automatic freq_t pitch_freq(int unsigned p);
        longint unsigned a;
        longint unsigned ip;
        longint unsigned r;
        int unsigned     q;
        q  = p / OCTAVE;
        a  = BASE_HZ * SEMITONE_RATIO[p % OCTAVE];
        ip = a / DEC_ONE;
        r  = a % DEC_ONE;
        for (int k = 0; k < MAX_OCT; k++)
        begin
            if (k < int'(q))
            begin
                r  = r * 64'd2;
                ip = ip * 64'd2;
                if (r >= DEC_ONE)
                begin
                    r  = r - DEC_ONE;
                    ip = ip + 64'd1;
                end
            end
        end
        return ip[FREQ_W-1:0];
    endfunction

    function automatic freq_rom_t build_rom();
        freq_rom_t rom;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            rom[i] = pitch_freq(i);
        end
        return rom;
    endfunction

    localparam freq_rom_t PITCH_ROM = build_rom();

endpackage

// ===== rtl/core/mns_if.sv =====
// Item and result channel interfaces of the note sequencer.
`timescale 1ns / 1ps

interface mns_item_if;
    logic                            valid;
    logic                            ready;
    logic                            command;
    logic [mns_pkg::ADDR_W-1:0]      write_address;
    logic [mns_pkg::PITCH_W-1:0]     write_pitch;
    logic [mns_pkg::DELAY_W-1:0]     write_delay;

    modport source (output valid, command, write_address, write_pitch, write_delay,
                    input ready);
    modport sink   (input valid, command, write_address, write_pitch, write_delay,
                    output ready);
endinterface

interface mns_result_if;
    logic                            valid;
    logic                            ready;
    logic [mns_pkg::CHANNEL_W-1:0]   channel;
    logic [mns_pkg::ACTION_W-1:0]    action;
    logic [mns_pkg::FREQ_W-1:0]      tone_frequency;
    logic [mns_pkg::SOUND_W-1:0]     drum_sound;
    logic [mns_pkg::PAN_W-1:0]       drum_pan;
    logic                            last_of_tick;

    modport source (output valid, channel, action, tone_frequency, drum_sound, drum_pan,
                    last_of_tick, input ready);
    modport sink   (input valid, channel, action, tone_frequency, drum_sound, drum_pan,
                    last_of_tick, output ready);
endinterface

// ===== rtl/core/multichannel_note_sequencer_core.sv =====
// Top level of the multichannel note sequencer.
// Write beat: written to song memory when taken; item ready stays high for the next item.
// Tick beat: item ready drops after accept; each channel is then checked in S_CHECK, and a
// due channel also passes S_ENTRY and S_NEXT, as the single song memory read port is used
// twice per due channel. A channel waits while the result slot is full.
// Reset clears positions, countdowns and start addresses; song memory is undefined.
`timescale 1ns / 1ps

module multichannel_note_sequencer_core #(
    parameter int SONG_DEPTH    = mns_pkg::DEFAULT_SONG_DEPTH,
    parameter int CHANNELS      = mns_pkg::DEFAULT_CHANNELS,
    parameter int PITCH_ENTRIES = mns_pkg::DEFAULT_PITCH_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mns_item_if.sink                        item,
    mns_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [mns_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mns_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CH_W = $clog2(CHANNELS);

    mns_pkg::mns_cmd_t    cmd;
    mns_pkg::mns_status_t status;
    logic [CH_W-1:0]      ch_sel;

    mns_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_command (item.command),
        .item_ready   (item.ready),
        .status       (status),
        .cmd          (cmd),
        .ch_sel       (ch_sel)
    );

    mns_datapath #(
        .SONG_DEPTH    (SONG_DEPTH),
        .CHANNELS      (CHANNELS),
        .PITCH_ENTRIES (PITCH_ENTRIES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .ch_sel        (ch_sel),
        .status        (status),
        .write_address (item.write_address),
        .write_pitch   (item.write_pitch),
        .write_delay   (item.write_delay),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result        (result)
    );

endmodule

// ===== rtl/core/mns_ctrl.sv =====
// Sequencer controller: accepts items and walks the channels of a tick.
`timescale 1ns / 1ps

module mns_ctrl #(
    parameter int CHANNELS = mns_pkg::DEFAULT_CHANNELS,
    localparam int CH_W    = $clog2(CHANNELS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_command,
    output logic                item_ready,
    input  mns_pkg::mns_status_t status,
    output mns_pkg::mns_cmd_t    cmd,
    output logic [CH_W-1:0]     ch_sel
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_ENTRY = 2'd2;
    localparam logic [1:0] S_NEXT  = 2'd3;

    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    logic [CH_W-1:0] ch_reg;
    logic [CH_W-1:0] ch_next;
    logic            last_ch;

    assign last_ch    = (ch_reg == CH_W'(CHANNELS - 1));
    assign ch_sel     = ch_reg;
    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item_command == mns_pkg::CMD_WRITE)
                    begin
                        cmd.mem_write = 1'b1;
                    end
                    else
                    begin
                        ch_next    = '0;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (status.due)
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_ENTRY;
                end
                else if (status.slot_free)
                begin
                    cmd.commit_skip = 1'b1;
                    ch_next         = last_ch ? ch_reg : ch_reg + 1'b1;
                    state_next      = last_ch ? S_IDLE : S_CHECK;
                end
            end
            S_ENTRY:
            begin
                cmd.latch_entry = 1'b1;
                cmd.rd_next     = 1'b1;
                state_next      = S_NEXT;
            end
            S_NEXT:
            begin
                if (status.slot_free)
                begin
                    cmd.commit_due = 1'b1;
                    ch_next        = last_ch ? ch_reg : ch_reg + 1'b1;
                    state_next     = last_ch ? S_IDLE : S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

// ===== rtl/core/mns_datapath.sv =====
// Sequencer datapath: song memory, channel state, pitch table and result register.
`timescale 1ns / 1ps

module mns_datapath #(
    parameter int SONG_DEPTH    = mns_pkg::DEFAULT_SONG_DEPTH,
    parameter int CHANNELS      = mns_pkg::DEFAULT_CHANNELS,
    parameter int PITCH_ENTRIES = mns_pkg::DEFAULT_PITCH_ENTRIES,
    localparam int CH_W         = $clog2(CHANNELS),
    localparam int AW           = $clog2(SONG_DEPTH)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mns_pkg::mns_cmd_t                  cmd,
    input  logic [CH_W-1:0]                    ch_sel,
    output mns_pkg::mns_status_t               status,
    input  logic [mns_pkg::ADDR_W-1:0]         write_address,
    input  logic [mns_pkg::PITCH_W-1:0]        write_pitch,
    input  logic [mns_pkg::DELAY_W-1:0]        write_delay,
    input  logic                               cfg_we,
    input  logic [mns_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mns_pkg::CFG_DATA_W-1:0]     cfg_data,
    mns_result_if.source                       result
);

    logic [mns_pkg::ENTRY_W-1:0] song_mem [SONG_DEPTH];
    logic [mns_pkg::ENTRY_W-1:0] rd_data_reg;
    logic [mns_pkg::ENTRY_W-1:0] entry_reg;

    logic [AW-1:0]                     pos_reg   [CHANNELS];
    logic [AW-1:0]                     start_reg [CHANNELS];
    logic signed [mns_pkg::COUNT_W-1:0] cd_reg   [CHANNELS];

    logic [AW-1:0] cur_pos;
    logic [AW-1:0] next_pos;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] new_pos;
    logic          rd_en;
    logic          is_drum;
    logic          commit;

    logic [mns_pkg::PITCH_W-1:0]       entry_pitch;
    logic [mns_pkg::DELAY_W-1:0]       entry_delay;
    logic [mns_pkg::DELAY_W-1:0]       next_delay;
    logic signed [mns_pkg::COUNT_W-1:0] cd_cur;
    logic signed [mns_pkg::COUNT_W-1:0] cd_new;

    logic                             out_valid_reg;
    logic [mns_pkg::CHANNEL_W-1:0]    channel_reg;
    logic [mns_pkg::ACTION_W-1:0]     action_reg;
    logic [mns_pkg::ACTION_W-1:0]     action_next;
    mns_pkg::freq_t                   freq_reg;
    mns_pkg::freq_t                   freq_next;
    logic [mns_pkg::SOUND_W-1:0]      sound_reg;
    logic [mns_pkg::SOUND_W-1:0]      sound_next;
    logic [mns_pkg::PAN_W-1:0]        pan_reg;
    logic [mns_pkg::PAN_W-1:0]        pan_next;
    logic                             last_reg;

    assign cur_pos  = pos_reg[ch_sel];
    assign next_pos = (cur_pos == AW'(SONG_DEPTH - 1)) ? '0 : cur_pos + 1'b1;
    assign rd_addr  = cmd.rd_next ? next_pos : cur_pos;
    assign rd_en    = cmd.rd_cur | cmd.rd_next;
    assign wr_addr  = AW'(write_address);

    assign entry_pitch = entry_reg[mns_pkg::ENTRY_W-1:mns_pkg::DELAY_W];
    assign entry_delay = entry_reg[mns_pkg::DELAY_W-1:0];
    assign next_delay  = rd_data_reg[mns_pkg::DELAY_W-1:0];
    assign new_pos     = (next_delay == '0) ? start_reg[ch_sel] : next_pos;

    assign cd_cur  = cd_reg[ch_sel];
    assign cd_new  = cmd.commit_due
                   ? $signed({1'b0, entry_delay}) - 9'sd1
                   : cd_cur - 9'sd1;
    assign commit  = cmd.commit_due | cmd.commit_skip;
    assign is_drum = (CHANNELS > mns_pkg::DRUM_CHANNEL)
                   && (32'(ch_sel) == mns_pkg::DRUM_CHANNEL);

    assign status.due       = (cd_cur <= 9'sd0);
    assign status.slot_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            song_mem[wr_addr] <= {write_pitch, write_delay};
        end
        if (rd_en)
        begin
            rd_data_reg <= song_mem[rd_addr];
        end
        if (cmd.latch_entry)
        begin
            entry_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                pos_reg[c]   <= '0;
                start_reg[c] <= '0;
                cd_reg[c]    <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (cfg_we && c < mns_pkg::NUM_START_REGS && 32'(cfg_index) == c)
                begin
                    start_reg[c] <= AW'(cfg_data);
                    pos_reg[c]   <= AW'(cfg_data);
                end
                if (commit && ch_sel == CH_W'(c))
                begin
                    cd_reg[c] <= cd_new;
                    if (cmd.commit_due)
                    begin
                        pos_reg[c] <= new_pos;
                    end
                end
            end
        end
    end

    always_comb
    begin
        action_next = mns_pkg::ACT_NONE;
        freq_next   = '0;
        sound_next  = '0;
        pan_next    = '0;
        if (cmd.commit_due)
        begin
            if (is_drum)
            begin
                action_next = mns_pkg::ACT_DRUM;
                case (entry_pitch)
                    mns_pkg::NOTE_BASS:
                    begin
                        sound_next = mns_pkg::SND_BASS;
                        pan_next   = mns_pkg::PAN_BASS;
                    end
                    mns_pkg::NOTE_SNARE:
                    begin
                        sound_next = mns_pkg::SND_SNARE;
                        pan_next   = mns_pkg::PAN_SNARE;
                    end
                    default:
                    begin
                        sound_next = mns_pkg::SND_HIHAT;
                        pan_next   = mns_pkg::PAN_HIHAT;
                    end
                endcase
            end
            else if (entry_pitch != '0)
            begin
                action_next = mns_pkg::ACT_TONE;
                if (32'(entry_pitch) < PITCH_ENTRIES)
                begin
                    freq_next = mns_pkg::PITCH_ROM[entry_pitch];
                end
            end
            else
            begin
                action_next = mns_pkg::ACT_STOP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            channel_reg <= mns_pkg::CHANNEL_W'(ch_sel);
            action_reg  <= action_next;
            freq_reg    <= freq_next;
            sound_reg   <= sound_next;
            pan_reg     <= pan_next;
            last_reg    <= (ch_sel == CH_W'(CHANNELS - 1));
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.channel        = channel_reg;
    assign result.action         = action_reg;
    assign result.tone_frequency = freq_reg;
    assign result.drum_sound     = sound_reg;
    assign result.drum_pan       = pan_reg;
    assign result.last_of_tick   = last_reg;

endmodule

// ===== rtl/core/mns_checker.sv =====
// Port-level assertions for the note sequencer, bound to the top level.
`timescale 1ns / 1ps

module mns_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            item_valid,
    input logic                            item_ready,
    input logic                            item_command,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [mns_pkg::CHANNEL_W-1:0]   channel,
    input logic [mns_pkg::ACTION_W-1:0]    action,
    input logic [mns_pkg::FREQ_W-1:0]      tone_frequency,
    input logic [mns_pkg::SOUND_W-1:0]     drum_sound,
    input logic [mns_pkg::PAN_W-1:0]       drum_pan
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(action) && $stable(channel))
        else $error("stalled result beat changed");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_command == mns_pkg::CMD_TICK |=> !item_ready)
        else $error("item taken during a tick");

    a_tone_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && action != mns_pkg::ACT_TONE |-> tone_frequency == '0)
        else $error("frequency on a non-tone beat");

    a_drum_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && action != mns_pkg::ACT_DRUM |-> drum_sound == '0 && drum_pan == '0)
        else $error("drum fields on a non-drum beat");

    a_drum_channel: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && action == mns_pkg::ACT_DRUM
            |-> channel == mns_pkg::CHANNEL_W'(mns_pkg::DRUM_CHANNEL))
        else $error("drum beat on a tone channel");

endmodule

bind multichannel_note_sequencer_core mns_checker u_mns_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_command   (item.command),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .channel        (result.channel),
    .action         (result.action),
    .tone_frequency (result.tone_frequency),
    .drum_sound     (result.drum_sound),
    .drum_pan       (result.drum_pan)
);
